// ===== rtl/uniform_bspline_curve_sampler_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the B-spline curve sampler
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the synchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef UNIFORM_BSPLINE_CURVE_SAMPLER_ASSERT_SVH
`define UNIFORM_BSPLINE_CURVE_SAMPLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsc assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define BSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsc assertion failed in the next cycle");

`endif

// ===== rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Types, constants and helper functions shared by the curve sampler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

    localparam int MAX_POINTS   = 32;
    localparam int PTR_W        = 5;
    localparam int CNT_W        = 6;
    localparam int MAX_ORDER    = 8;
    localparam int IDX_W        = 3;
    localparam int MAX_SEGMENTS = 63;
    localparam int SEG_W        = 6;
    localparam int ORD_W        = 4;
    localparam int COORD_W      = 32;
    localparam int BASIS_W      = 18;
    localparam int DIV_W        = 21;
    localparam int DIV_CNT_W    = 5;
    localparam int RECIP_W      = 25;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 6;

    localparam logic [ORD_W-1:0]   ORDER_RESET   = 4'd4;
    localparam logic [SEG_W-1:0]   SEGMENT_RESET = 6'd16;
    localparam logic [ORD_W-1:0]   ORDER_MAX     = 4'd8;
    localparam logic [ORD_W-1:0]   ORDER_MIN     = 4'd2;
    localparam logic [BASIS_W-1:0] BASIS_ONE     = 18'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPLINE_ORDER  = 1'b0,
        REG_SEGMENT_COUNT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic                      final_point;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] curve_x;
        logic signed [COORD_W-1:0] curve_y;
        logic signed [COORD_W-1:0] curve_z;
        logic signed [COORD_W-1:0] curve_param;
        logic [SEG_W-1:0]          sample_index;
        logic                      last_sample;
        logic                      points_dropped;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_DIV,
        S_SPAN,
        S_B_LO,
        S_B_HI,
        S_B_SCALE,
        S_B_FIX,
        S_S_RD,
        S_S_MUL,
        S_S_ACC,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_STORE,
        OP_SETUP,
        OP_STEP_INIT,
        OP_SPAN,
        OP_B_LO,
        OP_B_HI,
        OP_B_SCALE,
        OP_B_FIX,
        OP_S_RD,
        OP_S_MUL,
        OP_S_ACC,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [SEG_W-1:0] j;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] m;
    } t_cmd;

    typedef struct packed {
        logic             order_ok;
        logic             div_done;
        logic             last;
        logic [IDX_W-1:0] deg;
    } t_status;

    // floor(2^24 / k) for the recursion level k.
    function automatic logic [RECIP_W-1:0] recip(input logic [IDX_W-1:0] k);
        logic [RECIP_W-1:0] r;
        case (k)
            3'd1:    r = 25'd16777216;
            3'd2:    r = 25'd8388608;
            3'd3:    r = 25'd5592405;
            3'd4:    r = 25'd4194304;
            3'd5:    r = 25'd3355443;
            3'd6:    r = 25'd2796202;
            3'd7:    r = 25'd2396745;
            default: r = 25'd0;
        endcase
        return r;
    endfunction

    // Saturate a 38-bit signed value to 32 bits.
    function automatic logic [COORD_W-1:0] sat32(input logic signed [37:0] v);
        logic [COORD_W-1:0] r;
        if (v[37:31] != {7{v[37]}}) begin
            r = v[37] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bsc_div.sv =====
// ----------------------------------------------------------------------------
// bsc_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsc_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [bsc_pkg::DIV_W-1:0]    i_dividend,
    input  wire logic [bsc_pkg::SEG_W-1:0]    i_divisor,
    output logic                              o_done,
    output logic [bsc_pkg::DIV_W-1:0]         o_quotient,
    output logic [bsc_pkg::SEG_W-1:0]         o_remainder
);

    logic [bsc_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_done;
    logic [bsc_pkg::DIV_W-1:0]     r_quo;
    logic [bsc_pkg::SEG_W:0]       r_rem;
    logic [bsc_pkg::SEG_W-1:0]     r_divisor;
    logic [bsc_pkg::SEG_W:0]       w_trial;
    logic                          w_ge;

    assign w_trial = {r_rem[bsc_pkg::SEG_W-1:0], r_quo[bsc_pkg::DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= bsc_pkg::DIV_CNT_W'(bsc_pkg::DIV_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == bsc_pkg::DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo     <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[bsc_pkg::DIV_W-2:0], w_ge};
            r_rem <= w_ge ? (w_trial - {1'b0, r_divisor}) : w_trial;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem[bsc_pkg::SEG_W-1:0];

endmodule

`default_nettype wire

// ===== rtl/bsc_dp.sv =====
// ----------------------------------------------------------------------------
// bsc_dp
// Datapath: point store, parameter stepping, basis recursion and weighted sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsc_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bsc_pkg::t_cmd                     i_cmd,
    output bsc_pkg::t_status                       o_status,
    input  wire bsc_pkg::t_in_item                 i_item,
    input  wire logic                              i_cfg_we,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bsc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                   o_strobe,
    output bsc_pkg::t_out_item                     o_result
);

    // Configuration and point store.
    logic [bsc_pkg::ORD_W-1:0]   r_spline_order;
    logic [bsc_pkg::SEG_W-1:0]   r_segment_count;
    logic [bsc_pkg::CNT_W-1:0]   r_point_count;
    logic                        r_overflow;
    logic [3*bsc_pkg::COORD_W-1:0] r_mem [bsc_pkg::MAX_POINTS];
    logic [3*bsc_pkg::COORD_W-1:0] r_rd;

    // Run parameters.
    logic [bsc_pkg::IDX_W-1:0]   r_deg;
    logic [bsc_pkg::SEG_W-1:0]   r_segs;
    logic [bsc_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_neg;
    logic signed [31:0]          r_t;
    logic signed [31:0]          r_stepq;
    logic [bsc_pkg::SEG_W-1:0]   r_stepr;
    logic [bsc_pkg::SEG_W-1:0]   r_tr;
    logic                        r_last;
    logic signed [7:0]           r_s;
    logic [16:0]                 r_f;

    // Basis recursion.
    logic [bsc_pkg::BASIS_W-1:0] r_b [bsc_pkg::MAX_ORDER];
    logic [bsc_pkg::BASIS_W-1:0] r_carry;
    logic [bsc_pkg::BASIS_W-1:0] r_hi;
    logic [38:0]                 r_num;
    logic [22:0]                 r_v;
    logic [47:0]                 r_prod;

    // Weighted sum.
    logic                        r_sv;
    logic [bsc_pkg::BASIS_W-1:0] r_nb;
    logic signed [50:0]          r_p [3];
    logic signed [53:0]          r_acc [3];

    logic                        r_strobe;
    bsc_pkg::t_out_item          r_result;

    // Divider interface.
    logic                        w_div_done;
    logic [bsc_pkg::DIV_W-1:0]   w_div_quo;
    logic [bsc_pkg::SEG_W-1:0]   w_div_rem;

    // Combinational helpers.
    logic [bsc_pkg::ORD_W-1:0]   w_ord;
    logic                        w_order_ok;
    logic [bsc_pkg::IDX_W-1:0]   w_deg;
    logic [bsc_pkg::SEG_W-1:0]   w_segs;
    logic signed [7:0]           w_diff;
    logic [7:0]                  w_diff_neg;
    logic [4:0]                  w_mag;
    logic [bsc_pkg::DIV_W-1:0]   w_dividend;
    logic                        w_rem_nz;
    logic [31:0]                 w_qmag;
    logic signed [31:0]          w_stepq;
    logic [bsc_pkg::SEG_W-1:0]   w_stepr;
    logic [31:0]                 w_t0;
    logic                        w_last;
    logic signed [31:0]          w_tm;
    logic [bsc_pkg::IDX_W-1:0]   w_km;
    logic [19:0]                 w_a;
    logic [bsc_pkg::BASIS_W-1:0] w_lo;
    logic [37:0]                 w_plo;
    logic [3:0]                  w_m1;
    logic [19:0]                 w_bb;
    logic [bsc_pkg::BASIS_W-1:0] w_hi;
    logic [37:0]                 w_phi;
    logic [38:0]                 w_round;
    logic [22:0]                 w_v;
    logic [47:0]                 w_prod;
    logic [23:0]                 w_q0;
    logic [26:0]                 w_qk;
    logic [26:0]                 w_r;
    logic [23:0]                 w_q;
    logic signed [7:0]           w_idx;
    logic [7:0]                  w_addr;
    logic                        w_valid;
    logic signed [18:0]          w_nbs;
    logic [6:0]                  w_tr_sum;
    logic                        w_wrap;
    logic signed [53:0]          w_ra [3];

    assign w_ord      = (r_spline_order > bsc_pkg::ORDER_MAX) ? bsc_pkg::ORDER_MAX
                                                              : r_spline_order;
    assign w_order_ok = (w_ord >= bsc_pkg::ORDER_MIN);
    assign w_deg      = bsc_pkg::IDX_W'(w_ord - 4'd1);
    assign w_segs     = (r_segment_count == '0) ? bsc_pkg::SEG_W'(1) : r_segment_count;

    assign w_diff     = $signed({2'b00, r_point_count}) - $signed({5'b00000, w_deg});
    assign w_diff_neg = 8'd0 - w_diff;
    assign w_mag      = w_diff[7] ? w_diff_neg[4:0] : w_diff[4:0];
    assign w_dividend = {w_mag, 16'h0000};

    // Per-sample step of the parameter: quotient and non-negative remainder.
    assign w_rem_nz = (w_div_rem != '0);
    assign w_qmag   = {11'd0, w_div_quo} + {31'd0, w_rem_nz};
    assign w_stepq  = r_neg ? $signed(32'd0 - w_qmag) : $signed({11'd0, w_div_quo});
    assign w_stepr  = (r_neg && w_rem_nz) ? (r_segs - w_div_rem) : w_div_rem;
    assign w_t0     = {12'd0, 4'({1'b0, r_deg} + 4'd1), 16'h0000};

    // The last sample takes the left limit, so its span is ceil(t) - 1.
    assign w_last = (i_cmd.j == r_segs);
    assign w_tm   = w_last ? (r_t - 32'sd1) : r_t;

    assign w_km   = i_cmd.k - i_cmd.m;
    assign w_a    = {1'b0, w_km, 16'h0000} + {3'b000, r_f};
    assign w_lo   = (i_cmd.m == '0) ? '0 : r_carry;
    assign w_plo  = w_a * w_lo;
    assign w_m1   = {1'b0, i_cmd.m} + 4'd1;
    assign w_bb   = {w_m1, 16'h0000} - {3'b000, r_f};
    assign w_hi   = (i_cmd.m == i_cmd.k) ? '0 : r_hi;
    assign w_phi  = w_bb * w_hi;

    // Division by k*2^16 with rounding: shift, then multiply by 1/k and fix up.
    assign w_round = r_num + {21'd0, i_cmd.k, 15'd0};
    assign w_v     = w_round[38:16];
    assign w_prod  = w_v * bsc_pkg::recip(i_cmd.k);
    assign w_q0    = r_prod[47:24];
    assign w_qk    = w_q0 * i_cmd.k;
    assign w_r     = {4'd0, r_v} - w_qk;
    assign w_q     = (w_r >= {24'd0, i_cmd.k}) ? (w_q0 + 24'd1) : w_q0;

    assign w_idx   = r_s - $signed({5'b00000, r_deg}) + $signed({5'b00000, i_cmd.m});
    assign w_addr  = w_idx - 8'sd1;
    assign w_valid = (w_idx >= 8'sd1) && (w_idx <= $signed({2'b00, r_cnt}))
                     && (r_b[i_cmd.m] != '0);
    assign w_nbs   = $signed({1'b0, r_nb});

    assign w_tr_sum = {1'b0, r_tr} + {1'b0, r_stepr};
    assign w_wrap   = (w_tr_sum >= {1'b0, r_segs});

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_ra[c] = r_acc[c] + 54'sd32768;
        end
    end

    bsc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.op == bsc_pkg::OP_SETUP),
        .i_dividend  (w_dividend),
        .i_divisor   (w_segs),
        .o_done      (w_div_done),
        .o_quotient  (w_div_quo),
        .o_remainder (w_div_rem)
    );

    // Control state: configuration, fill count, overflow and the strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spline_order  <= bsc_pkg::ORDER_RESET;
            r_segment_count <= bsc_pkg::SEGMENT_RESET;
            r_point_count   <= '0;
            r_overflow      <= 1'b0;
            r_strobe        <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.op == bsc_pkg::OP_EMIT);
            if (i_cfg_we) begin
                case (bsc_pkg::t_cfg_reg'(i_cfg_idx))
                    bsc_pkg::REG_SPLINE_ORDER:  r_spline_order  <= i_cfg_data[bsc_pkg::ORD_W-1:0];
                    bsc_pkg::REG_SEGMENT_COUNT: r_segment_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.op == bsc_pkg::OP_STORE) begin
                if (i_item.final_point && !w_order_ok) begin
                    r_point_count <= '0;
                    r_overflow    <= 1'b0;
                end else if (r_point_count < bsc_pkg::CNT_W'(bsc_pkg::MAX_POINTS)) begin
                    r_point_count <= r_point_count + 1'b1;
                end else begin
                    r_overflow <= 1'b1;
                end
            end else if (i_cmd.op == bsc_pkg::OP_EMIT && r_last) begin
                r_point_count <= '0;
                r_overflow    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == bsc_pkg::OP_STORE
            && r_point_count < bsc_pkg::CNT_W'(bsc_pkg::MAX_POINTS)) begin
            r_mem[r_point_count[bsc_pkg::PTR_W-1:0]] <=
                {i_item.point_x, i_item.point_y, i_item.point_z};
        end
        r_rd <= r_mem[w_addr[bsc_pkg::PTR_W-1:0]];
    end

    // Datapath payload registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            bsc_pkg::OP_SETUP: begin
                r_deg  <= w_deg;
                r_segs <= w_segs;
                r_cnt  <= r_point_count;
                r_neg  <= w_diff[7];
            end
            bsc_pkg::OP_STEP_INIT: begin
                r_stepq <= w_stepq;
                r_stepr <= w_stepr;
                r_t     <= $signed(w_t0);
                r_tr    <= '0;
            end
            bsc_pkg::OP_SPAN: begin
                r_last <= w_last;
                r_s    <= w_tm[23:16];
                r_f    <= {1'b0, w_tm[15:0]} + {16'd0, w_last};
                r_b[0] <= bsc_pkg::BASIS_ONE;
                for (int c = 0; c < 3; c++) begin
                    r_acc[c] <= '0;
                end
            end
            bsc_pkg::OP_B_LO: begin
                r_num <= {1'b0, w_plo};
                r_hi  <= r_b[i_cmd.m];
            end
            bsc_pkg::OP_B_HI: begin
                r_num <= r_num + {1'b0, w_phi};
            end
            bsc_pkg::OP_B_SCALE: begin
                r_v    <= w_v;
                r_prod <= w_prod;
            end
            bsc_pkg::OP_B_FIX: begin
                r_b[i_cmd.m] <= w_q[bsc_pkg::BASIS_W-1:0];
                r_carry      <= r_hi;
            end
            bsc_pkg::OP_S_RD: begin
                r_sv <= w_valid;
                r_nb <= r_b[i_cmd.m];
            end
            bsc_pkg::OP_S_MUL: begin
                r_p[0] <= r_sv ? ($signed(r_rd[95:64]) * w_nbs) : 51'sd0;
                r_p[1] <= r_sv ? ($signed(r_rd[63:32]) * w_nbs) : 51'sd0;
                r_p[2] <= r_sv ? ($signed(r_rd[31:0])  * w_nbs) : 51'sd0;
            end
            bsc_pkg::OP_S_ACC: begin
                for (int c = 0; c < 3; c++) begin
                    r_acc[c] <= r_acc[c] + {{3{r_p[c][50]}}, r_p[c]};
                end
            end
            bsc_pkg::OP_EMIT: begin
                r_result.curve_x        <= bsc_pkg::sat32(w_ra[0][53:16]);
                r_result.curve_y        <= bsc_pkg::sat32(w_ra[1][53:16]);
                r_result.curve_z        <= bsc_pkg::sat32(w_ra[2][53:16]);
                r_result.curve_param    <= r_t;
                r_result.sample_index   <= i_cmd.j;
                r_result.last_sample    <= r_last;
                r_result.points_dropped <= r_overflow;
                r_tr <= w_wrap ? 6'(w_tr_sum - {1'b0, r_segs}) : w_tr_sum[5:0];
                r_t  <= r_t + r_stepq + {31'd0, w_wrap};
            end
            default: ;
        endcase
    end

    assign o_status.order_ok = w_order_ok;
    assign o_status.div_done = w_div_done;
    assign o_status.last     = r_last;
    assign o_status.deg      = r_deg;
    assign o_strobe          = r_strobe;
    assign o_result          = r_result;

endmodule

`default_nettype wire

// ===== rtl/bsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsc_ctrl
// Sequencer: walks samples, recursion levels and basis entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "uniform_bspline_curve_sampler_assert.svh"

module bsc_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_final,
    input  wire bsc_pkg::t_status  i_status,
    output bsc_pkg::t_cmd          o_cmd,
    output logic                   o_busy
);

    bsc_pkg::t_state                r_state, n_state;
    logic [bsc_pkg::SEG_W-1:0]      r_j, n_j;
    logic [bsc_pkg::IDX_W-1:0]      r_k, n_k;
    logic [bsc_pkg::IDX_W-1:0]      r_m, n_m;
    bsc_pkg::t_op                   w_op;

    // Terms used by the checks at the end of the module.
    logic                           w_in_fix;
    logic                           w_fix_ok;
    logic                           w_in_acc;
    logic                           w_last_emit;
    logic                           w_run_go;
    logic                           w_setup_j0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bsc_pkg::S_IDLE;
            r_j     <= '0;
            r_k     <= '0;
            r_m     <= '0;
        end else begin
            r_state <= n_state;
            r_j     <= n_j;
            r_k     <= n_k;
            r_m     <= n_m;
        end
    end

    always_comb begin
        n_state = r_state;
        n_j     = r_j;
        n_k     = r_k;
        n_m     = r_m;
        w_op    = bsc_pkg::OP_NONE;
        case (r_state)
            bsc_pkg::S_IDLE: begin
                if (i_start) begin
                    w_op = bsc_pkg::OP_STORE;
                    if (i_final && i_status.order_ok) begin
                        n_state = bsc_pkg::S_SETUP;
                        n_j     = '0;
                    end
                end
            end
            bsc_pkg::S_SETUP: begin
                w_op    = bsc_pkg::OP_SETUP;
                n_state = bsc_pkg::S_DIV;
            end
            bsc_pkg::S_DIV: begin
                if (i_status.div_done) begin
                    w_op    = bsc_pkg::OP_STEP_INIT;
                    n_state = bsc_pkg::S_SPAN;
                end
            end
            bsc_pkg::S_SPAN: begin
                w_op    = bsc_pkg::OP_SPAN;
                n_k     = bsc_pkg::IDX_W'(1);
                n_m     = '0;
                n_state = bsc_pkg::S_B_LO;
            end
            bsc_pkg::S_B_LO: begin
                w_op    = bsc_pkg::OP_B_LO;
                n_state = bsc_pkg::S_B_HI;
            end
            bsc_pkg::S_B_HI: begin
                w_op    = bsc_pkg::OP_B_HI;
                n_state = bsc_pkg::S_B_SCALE;
            end
            bsc_pkg::S_B_SCALE: begin
                w_op    = bsc_pkg::OP_B_SCALE;
                n_state = bsc_pkg::S_B_FIX;
            end
            bsc_pkg::S_B_FIX: begin
                w_op = bsc_pkg::OP_B_FIX;
                if (r_m == r_k) begin
                    n_m = '0;
                    if (r_k == i_status.deg) begin
                        n_state = bsc_pkg::S_S_RD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = bsc_pkg::S_B_LO;
                    end
                end else begin
                    n_m     = r_m + 1'b1;
                    n_state = bsc_pkg::S_B_LO;
                end
            end
            bsc_pkg::S_S_RD: begin
                w_op    = bsc_pkg::OP_S_RD;
                n_state = bsc_pkg::S_S_MUL;
            end
            bsc_pkg::S_S_MUL: begin
                w_op    = bsc_pkg::OP_S_MUL;
                n_state = bsc_pkg::S_S_ACC;
            end
            bsc_pkg::S_S_ACC: begin
                w_op = bsc_pkg::OP_S_ACC;
                if (r_m == i_status.deg) begin
                    n_state = bsc_pkg::S_EMIT;
                end else begin
                    n_m     = r_m + 1'b1;
                    n_state = bsc_pkg::S_S_RD;
                end
            end
            bsc_pkg::S_EMIT: begin
                w_op = bsc_pkg::OP_EMIT;
                if (i_status.last) begin
                    n_state = bsc_pkg::S_IDLE;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = bsc_pkg::S_SPAN;
                end
            end
            default: begin
                n_state = bsc_pkg::S_IDLE;
            end
        endcase
    end

    assign o_cmd.op = w_op;
    assign o_cmd.j  = r_j;
    assign o_cmd.k  = r_k;
    assign o_cmd.m  = r_m;
    assign o_busy   = (r_state != bsc_pkg::S_IDLE);

    assign w_in_fix    = (r_state == bsc_pkg::S_B_FIX);
    assign w_fix_ok    = (r_m <= r_k) && (r_k <= i_status.deg) && (r_k != '0);
    assign w_in_acc    = (r_state == bsc_pkg::S_S_ACC);
    assign w_last_emit = (r_state == bsc_pkg::S_EMIT) && i_status.last;
    assign w_run_go    = (r_state == bsc_pkg::S_IDLE) && i_start && i_final
                         && i_status.order_ok;
    assign w_setup_j0  = (r_state == bsc_pkg::S_SETUP) && (r_j == '0);

    `BSC_ASSERT_NOW(a_fix_index, i_clk, i_rst_n, w_in_fix, w_fix_ok)
    `BSC_ASSERT_NOW(a_sum_index, i_clk, i_rst_n, w_in_acc, r_m <= i_status.deg)
    `BSC_ASSERT_NEXT(a_last_done, i_clk, i_rst_n, w_last_emit, r_state == bsc_pkg::S_IDLE)
    `BSC_ASSERT_NEXT(a_run_start, i_clk, i_rst_n, w_run_go, w_setup_j0)

endmodule

`default_nettype wire

// ===== rtl/uniform_bspline_curve_sampler.sv =====
// ----------------------------------------------------------------------------
// uniform_bspline_curve_sampler
// Samples a uniform integer-knot B-spline through stored control points.
// ----------------------------------------------------------------------------
// Usage: control points enter one per transfer on i_item when start is high
// and busy is low. Up to 32 points are stored; further points are dropped and
// the points_dropped flag is raised on the results of that run. The transfer
// with final_point set starts sampling: segment_count + 1 results follow
// (zero counts as one), each shown on o_result for exactly one cycle while
// o_strobe is high. The receiver cannot stall, so every result must be taken
// in its strobe cycle. A non-final point is stored in idle. After the final
// point, setup computes the parameter step by division, one quotient bit per
// cycle; each sample of degree d = order - 1 then runs on the shared unit:
// S_B_LO, S_B_HI, S_B_SCALE, S_B_FIX per basis entry, then S_S_RD, S_S_MUL,
// S_S_ACC per weighted point. busy stays high until the cycle that shows
// the last result. An order below two gives no results. Configuration
// writes go on the plain write port and must only happen while busy is low.
// Reset restores order four and sixteen segments, and empties the point store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module uniform_bspline_curve_sampler (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire bsc_pkg::t_in_item                 i_item,
    input  wire logic                              i_cfg_we,
    input  wire logic [bsc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [bsc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                   o_strobe,
    output bsc_pkg::t_out_item                     o_result
);

    // Commands flow from the sequencer to the datapath, status flows back.
    bsc_pkg::t_cmd    w_cmd;
    bsc_pkg::t_status w_status;

    bsc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_final  (i_item.final_point),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (busy)
    );

    // The datapath holds the point memory, the configuration registers and
    // the output register that drives the result strobe.
    bsc_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );

endmodule

`default_nettype wire
